/* design/sdai_pkg.sv */
// ----------------------------------------------------------------------------
// sdai_pkg: shared types and constants for the integer to decimal text block
// Character codes, sizing functions, queue status and back end states.
// ----------------------------------------------------------------------------
package sdai_pkg;

   // Defaults for the top level parameters
   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Character codes
   localparam int CHAR_W = 6;
   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
   localparam logic [CHAR_W-1:0] MINUS_CODE = 6'd45;
   localparam int DECIMAL_BASE = 10;

   // Largest number of powers of ten ever needed (up to 10^19)
   localparam int MAX_POW = 20;

   // Queue fill status, from queue to front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Back end sequencer states
   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_SIGN,
      BACK_DIGIT
   } back_state_type;

   // 10^k as a 64-bit constant
   function automatic logic [63:0] pow10(input int k);
      logic [63:0] r;
      r = 64'd1;
      for (int i = 0; i < MAX_POW; i++) begin
         if (i < k) begin
            r = r * 64'(DECIMAL_BASE);
         end
      end
      return r;
   endfunction

   // Decimal digits in the largest magnitude, 2^(width-1)
   function automatic int num_digits(input int width);
      logic [63:0] p;
      int n;
      p = 64'd1 << (width - 1);
      n = 0;
      for (int i = 0; i < MAX_POW; i++) begin
         if (p != 64'd0) begin
            n = n + 1;
            p = p / DECIMAL_BASE;
         end
      end
      return n;
   endfunction

endpackage

/* design/sdai_front.sv */
// ----------------------------------------------------------------------------
// sdai_front: input side of the integer to decimal text block
// Takes a value beat, splits it into sign and magnitude, pushes to the queue.
// ----------------------------------------------------------------------------
module sdai_front #(
   parameter int VALUE_WIDTH = sdai_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                          req_valid,
   input  logic [VALUE_WIDTH-1:0]        req_value,
   output logic                          req_stall,
   input  sdai_pkg::queue_status_type    q_status,
   output logic                          q_push,
   output logic                          q_neg,
   output logic [VALUE_WIDTH-1:0]        q_mag
);

   // Hold off the sender while the queue has no room
   assign req_stall = q_status.full;
   assign q_push    = req_valid && !q_status.full;

   // Sign and magnitude; the most negative value maps to 2^(W-1) unsigned
   assign q_neg = req_value[VALUE_WIDTH-1];
   assign q_mag = q_neg ? (~req_value + VALUE_WIDTH'(1)) : req_value;

endmodule

/* design/sdai_queue.sv */
// ----------------------------------------------------------------------------
// sdai_queue: short queue between front and back
// Register based FIFO; read data is the head entry, shown combinationally.
// ----------------------------------------------------------------------------
module sdai_queue #(
   parameter int WIDTH = 33,
   parameter int DEPTH = sdai_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rd_data,
   output sdai_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Status
   always_comb begin
      status.full  = (count_ff == CNT_W'(DEPTH));
      status.empty = (count_ff == '0);
   end

   assign rd_data = mem_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // Fill count never exceeds the depth, never pops empty
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH)) else $error("queue count over depth");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty) else $error("queue popped while empty");

endmodule

/* design/sdai_back.sv */
// ----------------------------------------------------------------------------
// sdai_back: digit generator of the integer to decimal text block
// Takes sign and magnitude from the queue, emits the text one char a cycle while not stalled.
// ----------------------------------------------------------------------------
module sdai_back #(
   parameter int VALUE_WIDTH = sdai_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  sdai_pkg::queue_status_type       q_status,
   input  logic                             q_neg,
   input  logic [VALUE_WIDTH-1:0]           q_mag,
   output logic                             q_pop,
   output logic                             rsp_valid,
   output logic [sdai_pkg::CHAR_W-1:0]      rsp_char_code,
   output logic                             rsp_is_last,
   input  logic                             rsp_stall
);

   localparam int DIGITS = sdai_pkg::num_digits(VALUE_WIDTH);
   localparam int PW     = $clog2(DIGITS);
   localparam int TW     = VALUE_WIDTH + 4;

   sdai_pkg::back_state_type state_ff, state_in;

   logic [VALUE_WIDTH-1:0]          rem_ff, rem_in;
   logic [PW-1:0]                   pos_ff, pos_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [sdai_pkg::CHAR_W-1:0]     rsp_char_code_ff, rsp_char_code_in;
   logic                            rsp_is_last_ff, rsp_is_last_in;

   logic [TW-1:0]   step_tab [DIGITS][11];
   logic [PW-1:0]   top_pos;
   logic [TW:0]     diff [10];
   logic [3:0]      digit_val;
   logic [VALUE_WIDTH-1:0] rem_next;
   logic            emit_ok;
   logic            emit;

   // Constant table: c * 10^k
   always_comb begin
      for (int k = 0; k < DIGITS; k++) begin
         for (int c = 0; c < 11; c++) begin
            step_tab[k][c] = TW'(sdai_pkg::pow10(k) * 64'(c));
         end
      end
   end

   // Index of the leading digit of the queue head
   always_comb begin
      top_pos = '0;
      for (int k = 1; k < DIGITS; k++) begin
         if ({4'b0, q_mag} >= step_tab[k][1]) begin
            top_pos = top_pos + PW'(1);
         end
      end
   end

   // Current digit: parallel trial subtracts, keep the largest that fits
   always_comb begin
      digit_val = '0;
      rem_next  = rem_ff;
      diff[0]   = '0;
      for (int c = 1; c < 10; c++) begin
         diff[c] = {1'b0, 4'b0, rem_ff} - {1'b0, step_tab[pos_ff][c]};
      end
      for (int c = 1; c < 10; c++) begin
         if (!diff[c][TW]) begin
            digit_val = 4'(c);
            rem_next  = diff[c][VALUE_WIDTH-1:0];
         end
      end
   end

   assign emit_ok = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sdai_pkg::BACK_IDLE: begin
            if (!q_status.empty) begin
               state_in = q_neg ? sdai_pkg::BACK_SIGN : sdai_pkg::BACK_DIGIT;
            end
         end
         sdai_pkg::BACK_SIGN: begin
            if (emit_ok) begin
               state_in = sdai_pkg::BACK_DIGIT;
            end
         end
         sdai_pkg::BACK_DIGIT: begin
            if (emit_ok && pos_ff == '0) begin
               state_in = sdai_pkg::BACK_IDLE;
            end
         end
         default: state_in = sdai_pkg::BACK_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      q_pop            = 1'b0;
      emit             = 1'b0;
      rsp_char_code_in = sdai_pkg::ASCII_ZERO + sdai_pkg::CHAR_W'(digit_val);
      rsp_is_last_in   = 1'b0;
      unique case (state_ff)
         sdai_pkg::BACK_IDLE: begin
            q_pop = !q_status.empty;
         end
         sdai_pkg::BACK_SIGN: begin
            emit             = emit_ok;
            rsp_char_code_in = sdai_pkg::MINUS_CODE;
         end
         sdai_pkg::BACK_DIGIT: begin
            emit           = emit_ok;
            rsp_is_last_in = (pos_ff == '0);
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // Working value and digit position
   always_comb begin
      rem_in = rem_ff;
      pos_in = pos_ff;
      if (q_pop) begin
         rem_in = q_mag;
         pos_in = top_pos;
      end else if (emit && state_ff == sdai_pkg::BACK_DIGIT && pos_ff != '0) begin
         rem_in = rem_next;
         pos_in = pos_ff - PW'(1);
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdai_pkg::BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      pos_ff <= pos_in;
      if (emit) begin
         rsp_char_code_ff <= rsp_char_code_in;
         rsp_is_last_ff   <= rsp_is_last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_code_ff;
   assign rsp_is_last   = rsp_is_last_ff;

   // A taken entry always produces text
   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff != sdai_pkg::BACK_IDLE) else $error("pop without run");
   // Minus sign is never the final beat of a run
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_char_code_ff == sdai_pkg::MINUS_CODE |-> !rsp_is_last_ff)
      else $error("minus flagged last");
   // Remainder stays below 10^(pos+1), so each digit is 0..9
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == sdai_pkg::BACK_DIGIT |-> {4'b0, rem_ff} < step_tab[pos_ff][10])
      else $error("remainder out of range for digit position");

endmodule

/* design/signed_int_to_decimal_ascii_top.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top: signed integer to decimal ASCII text
// Front splits sign and magnitude, a queue decouples, back emits characters.
// ----------------------------------------------------------------------------
// Each accepted value beat yields its decimal text, one character per result
// beat, most significant first, with a leading minus for negative values and
// is_last on the final character. The back end loads a value from the queue
// in its idle state, then emits one character per cycle unless rsp_stall holds
// it back, as one digit unit resolves a digit by parallel trial subtraction
// of c * 10^k; the next value is loaded only after the last character. The
// front takes new values while the queue (QUEUE_DEPTH entries) has room, and the
// result register lets the back work ahead by one beat while rsp_stall is high.
module signed_int_to_decimal_ascii_top #(
   parameter int VALUE_WIDTH = sdai_pkg::VALUE_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = sdai_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [VALUE_WIDTH-1:0]       req_value,
   output logic                         req_stall,
   output logic                         rsp_valid,
   output logic [sdai_pkg::CHAR_W-1:0]  rsp_char_code,
   output logic                         rsp_is_last,
   input  logic                         rsp_stall
);

   sdai_pkg::queue_status_type q_status;
   logic                   q_push;
   logic                   q_pop;
   logic                   f_neg;
   logic [VALUE_WIDTH-1:0] f_mag;
   logic [VALUE_WIDTH:0]   head;

   // Classify input beats
   sdai_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .req_valid (req_valid),
      .req_value (req_value),
      .req_stall (req_stall),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_neg     (f_neg),
      .q_mag     (f_mag)
   );

   // Sign and magnitude queue
   sdai_queue #(
      .WIDTH(VALUE_WIDTH + 1),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data ({f_neg, f_mag}),
      .pop     (q_pop),
      .rd_data (head),
      .status  (q_status)
   );

   // Digit generation and output
   sdai_back #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_neg         (head[VALUE_WIDTH]),
      .q_mag         (head[VALUE_WIDTH-1:0]),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_char_code (rsp_char_code),
      .rsp_is_last   (rsp_is_last),
      .rsp_stall     (rsp_stall)
   );

endmodule

/* verif/signed_int_to_decimal_ascii_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top_tb: self-checking bench for the itoa block
// Sends signed values (corners first, then random ones by digit count, near
// powers of ten or the extremes, and raw words), predicts their decimal text
// and checks every char beat in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top_tb;

   localparam int VW = sdai_pkg::VALUE_WIDTH_DEFAULT;
   localparam int CW = sdai_pkg::CHAR_W;
   localparam int RANDOM_VALUES = 185;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 16;

   // One predicted character beat
   typedef struct packed {
      logic [CW-1:0] code;
      logic          last;
   } text_char_type;

   // One value waiting to be sent; drain_first holds it until all text is back
   typedef struct {
      logic [VW-1:0] value;
      bit            drain_first;
   } pending_value_type;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic [VW-1:0] req_value = '0;
   logic          req_stall;
   logic          rsp_valid;
   logic [CW-1:0] rsp_char_code;
   logic          rsp_is_last;
   logic          rsp_stall = 1'b0;

   pending_value_type values_to_send[$];
   text_char_type     expected_text[$];

   int             total_values = 0;
   int             accepted_values = 0;
   int             negative_values = 0;
   int             chars_checked = 0;
   int             mismatches = 0;
   int             cycle_count = 0;
   int             burst_left = 1;
   int             gap_left = 0;
   int             stall_left = 0;
   stall_mode_type stall_mode = STALL_NONE;

   signed_int_to_decimal_ascii_top #(
      .VALUE_WIDTH(VW)
   ) uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_value    (req_value),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_char_code(rsp_char_code),
      .rsp_is_last  (rsp_is_last),
      .rsp_stall    (rsp_stall)
   );

   // 50 MHz clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // 10^k in 64 bits
   function automatic logic [63:0] ten_to(input int k);
      logic [63:0] p;
      p = 64'd1;
      for (int i = 0; i < k; i++) begin
         p = p * 64'(sdai_pkg::DECIMAL_BASE);
      end
      return p;
   endfunction

   // Queue the decimal text of one value: sign, then digits MSD first
   function automatic void render_decimal(input logic [VW-1:0] v);
      logic [63:0]   mag;
      logic [3:0]    digit_buf [0:23];
      int            n;
      text_char_type c;
      mag = 64'(v);
      // widen before negating so the most negative value stays exact
      if (v[VW-1]) begin
         mag = ((~mag) + 64'd1) & ((64'd1 << VW) - 64'd1);
      end
      n = 0;
      do begin
         digit_buf[n] = 4'(mag % 64'(sdai_pkg::DECIMAL_BASE));
         mag = mag / 64'(sdai_pkg::DECIMAL_BASE);
         n++;
      end while (mag != 64'd0);
      if (v[VW-1]) begin
         c.code = sdai_pkg::MINUS_CODE;
         c.last = 1'b0;
         expected_text.push_back(c);
      end
      while (n > 0) begin
         n--;
         c.code = sdai_pkg::ASCII_ZERO + CW'(digit_buf[n]);
         c.last = (n == 0);
         expected_text.push_back(c);
      end
   endfunction

   // Sender: bursts of beats with random gaps; a beat holds until taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_value <= '0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (values_to_send.size() > 0 &&
                      (!values_to_send[0].drain_first ||
                       (!req_valid && expected_text.size() == 0))) begin
            req_valid <= 1'b1;
            req_value <= values_to_send[0].value;
            void'(values_to_send.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall pattern switches between modes at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 120);
         end else begin
            stall_left--;
         end
         case (stall_mode)
            STALL_NONE: begin
               rsp_stall <= 1'b0;
            end
            STALL_LIGHT: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            STALL_HEAVY: begin
               rsp_stall <= ($urandom_range(0, 1) == 0);
            end
            default: begin
               rsp_stall <= ((cycle_count % 5) < 2);
            end
         endcase
      end
   end

   // Monitor: check result beats first, then predict text for a taken value
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               $display("%0t: unexpected char beat code=%0d last=%0b",
                        $time, rsp_char_code, rsp_is_last);
               mismatches++;
            end else begin
               text_char_type want;
               want = expected_text.pop_front();
               if (rsp_char_code !== want.code) begin
                  $display("%0t: char_code expected %0d actual %0d",
                           $time, want.code, rsp_char_code);
                  mismatches++;
               end
               if (rsp_is_last !== want.last) begin
                  $display("%0t: is_last expected %0b actual %0b",
                           $time, want.last, rsp_is_last);
                  mismatches++;
               end
               chars_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            render_decimal(req_value);
            accepted_values++;
            if (req_value[VW-1]) begin
               negative_values++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   // Stimulus and end of run
   initial begin
      longint            corner_values[$];
      pending_value_type item;
      logic [63:0]       mag;
      logic [63:0]       lo;
      logic [63:0]       hi;
      logic [63:0]       cap;
      logic [63:0]       word;
      bit                neg;
      int                kind;
      int                nd;

      // corners: zero, one digit, carries across powers of ten, both extremes
      corner_values = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 5, -5,
                        999999999, 1000000000, -999999999, -1000000000,
                        123456789, -123456789, 2147483647, -2147483647,
                        -64'sd2147483648, 64'sh55555555, -64'sd715827883,
                        2000000000, -2147483640};
      foreach (corner_values[i]) begin
         item.value = corner_values[i][VW-1:0];
         item.drain_first = 1'b0;
         values_to_send.push_back(item);
      end

      // random mix; the first random value waits for the corner text to finish
      for (int i = 0; i < RANDOM_VALUES; i++) begin
         kind = $urandom_range(0, 9);
         neg = $urandom_range(0, 1);
         cap = neg ? (64'd1 << (VW - 1)) : (64'd1 << (VW - 1)) - 64'd1;
         if (kind <= 3) begin
            word = {32'd0, $urandom};
         end else begin
            if (kind <= 6) begin
               // uniform within a chosen digit count
               nd = $urandom_range(1, 10);
               lo = (nd == 1) ? 64'd0 : ten_to(nd - 1);
               hi = ten_to(nd) - 64'd1;
               if (hi > cap) begin
                  hi = cap;
               end
               mag = lo + ({$urandom, $urandom} % (hi - lo + 64'd1));
            end else if (kind <= 8) begin
               // just around a power of ten
               mag = ten_to($urandom_range(0, 9)) + 64'($urandom_range(0, 2)) - 64'd1;
            end else begin
               mag = cap - 64'($urandom_range(0, 2));
            end
            word = neg ? (~mag) + 64'd1 : mag;
         end
         item.value = word[VW-1:0];
         item.drain_first = (i == 0) || ($urandom_range(0, 39) == 0);
         values_to_send.push_back(item);
      end
      total_values = values_to_send.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (accepted_values < total_values) begin
         @(posedge clock);
      end
      while (expected_text.size() > 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Converted %0d values (%0d negative) into %0d checked characters,",
               accepted_values, negative_values, chars_checked);
      $display("with sender gaps, receiver stalls and drained pauses; %0d mismatches.",
               mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
